[src/gwm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Glob matcher package
// Transaction codes, wildcard bytes and the structs shared by the cell row.
// ----------------------------------------------------------------------------
package gwm_pkg;

   typedef enum logic [1:0] {
      REQ_CLEAR   = 2'd0,
      REQ_APPEND  = 2'd1,
      REQ_SUBJECT = 2'd2,
      REQ_END     = 2'd3
   } req_code_type;

   localparam logic [7:0] ANY_ONE = 8'h3F;
   localparam logic [7:0] ANY_RUN = 8'h2A;

   // Command broadcast to every cell for the transaction being accepted.
   typedef struct packed {
      logic       clear;
      logic       append;
      logic       subject;
      logic       rearm;
      logic [7:0] byte_value;
   } ctrl_type;

   // Signals handed from one cell to its right-hand neighbour.
   typedef struct packed {
      logic first;
      logic used;
      logic carry;
      logic match;
   } link_type;

endpackage
`default_nettype wire

[src/gwm_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Glob matcher cell
// Holds one pattern byte, its in-use bit and the active bit of its position.
// ----------------------------------------------------------------------------
module gwm_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire gwm_pkg::ctrl_type ctrl,
   input  wire gwm_pkg::link_type link_left,
   output gwm_pkg::link_type      link_right,
   output logic                   at_end
);

   logic [7:0] pat_ff;
   logic [7:0] pat_in;
   logic       used_ff;
   logic       used_in;
   logic       active_ff;
   logic       active_in;
   logic       closed;
   logic       is_star;
   logic       is_any;
   logic       load;

   assign closed  = active_ff | link_left.carry;
   assign is_star = (pat_ff == gwm_pkg::ANY_RUN);
   assign is_any  = (pat_ff == gwm_pkg::ANY_ONE);
   assign load    = ctrl.append & link_left.used & ~used_ff;

   assign link_right.first = 1'b0;
   assign link_right.used  = used_ff;
   assign link_right.carry = closed & used_ff & is_star;
   assign link_right.match = closed & used_ff & ~is_star &
                             (is_any | (pat_ff == ctrl.byte_value));
   assign at_end           = closed & link_left.used & ~used_ff;

   always_comb begin
      pat_in    = pat_ff;
      used_in   = used_ff;
      active_in = active_ff;
      if (ctrl.clear) begin
         used_in   = 1'b0;
         active_in = link_left.first;
      end else if (ctrl.rearm) begin
         active_in = link_left.first;
      end else if (ctrl.subject) begin
         active_in = link_right.carry | link_left.match;
      end else if (load) begin
         pat_in  = ctrl.byte_value;
         used_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
      if (reset) begin
         used_ff   <= 1'b0;
         active_ff <= link_left.first;
      end else begin
         used_ff   <= used_in;
         active_ff <= active_in;
      end
   end

endmodule
`default_nettype wire

[src/glob_wildcard_match.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Glob wildcard matcher
// Streams a subject past a loaded glob pattern held in a row of cells and
// reports whether the whole subject matched the whole pattern.
// ----------------------------------------------------------------------------
//  Channel  Direction  Ports                                 Transactions
//  req      in         req_valid/ready, req_type, req_byte_value  all codes
//  rsp      out        rsp_valid/ready, rsp_matched,          one per end
//                      rsp_pattern_overflow
//
// One transaction per cycle is sustained unless a held verdict stalls req; the
// ripple of '*' closure along the cell row sets the clock period.
// A verdict appears in the output register the cycle after its end
// transaction; new transactions are taken while that register drains.
// Reset empties the pattern and arms position zero.
// ----------------------------------------------------------------------------
module glob_wildcard_match #(
   parameter int MAX_PATTERN = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_type,
   input  wire logic [7:0] req_byte_value,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_matched,
   output logic            rsp_pattern_overflow
);

   gwm_pkg::ctrl_type              ctrl;
   gwm_pkg::link_type              links [MAX_PATTERN+1];
   logic [MAX_PATTERN-1:0]         cell_end;
   logic                           req_accept;
   logic                           tail_ff;
   logic                           tail_in;
   logic                           tail_closed;
   logic                           ovf_ff;
   logic                           ovf_in;
   logic                           hit;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic                           matched_ff;
   logic                           matched_in;
   logic                           rsp_ovf_ff;
   logic                           rsp_ovf_in;

   assign req_ready  = ~rsp_valid_ff | rsp_ready;
   assign req_accept = req_valid & req_ready;

   assign ctrl.clear      = req_accept & (req_type == gwm_pkg::REQ_CLEAR);
   assign ctrl.append     = req_accept & (req_type == gwm_pkg::REQ_APPEND);
   assign ctrl.subject    = req_accept & (req_type == gwm_pkg::REQ_SUBJECT);
   assign ctrl.rearm      = req_accept & (req_type == gwm_pkg::REQ_END);
   assign ctrl.byte_value = req_byte_value;

   assign links[0].first = 1'b1;
   assign links[0].used  = 1'b1;
   assign links[0].carry = 1'b0;
   assign links[0].match = 1'b0;

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      gwm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .link_left  (links[i]),
         .link_right (links[i+1]),
         .at_end     (cell_end[i])
      );
   end

   assign tail_closed = tail_ff | links[MAX_PATTERN].carry;
   assign hit = (|cell_end) | (tail_closed & links[MAX_PATTERN].used);

   always_comb begin
      tail_in      = tail_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      matched_in   = matched_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (ctrl.clear) begin
         tail_in = 1'b0;
         ovf_in  = 1'b0;
      end else if (ctrl.append) begin
         ovf_in = ovf_ff | links[MAX_PATTERN].used;
      end else if (ctrl.subject) begin
         tail_in = links[MAX_PATTERN].match;
      end else if (ctrl.rearm) begin
         tail_in      = 1'b0;
         rsp_valid_in = 1'b1;
         matched_in   = hit & ~ovf_ff;
         rsp_ovf_in   = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      matched_ff <= matched_in;
      rsp_ovf_ff <= rsp_ovf_in;
      if (reset) begin
         tail_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tail_ff      <= tail_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matched          = matched_ff;
   assign rsp_pattern_overflow = rsp_ovf_ff;

endmodule
`default_nettype wire

[src/gwm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Glob matcher checker
// Port-level properties of the matcher, attached to the top level by bind.
// ----------------------------------------------------------------------------
module gwm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [1:0] req_type,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_matched,
   input wire logic       rsp_pattern_overflow
);

   logic end_take;
   logic clear_take;

   assign end_take   = req_valid & req_ready & (req_type == gwm_pkg::REQ_END);
   assign clear_take = req_valid & req_ready & (req_type == gwm_pkg::REQ_CLEAR);

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid & ~rsp_ready |=> rsp_valid & $stable(rsp_matched)
         & $stable(rsp_pattern_overflow))
      else $error("Stalled response transaction changed.");

   a_end_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      end_take |=> rsp_valid)
      else $error("End transaction produced no response.");

   a_rsp_cause : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(end_take))
      else $error("Response appeared without an end transaction.");

   a_empty_ready : assert property (@(posedge clock) disable iff (reset)
      ~rsp_valid |-> req_ready)
      else $error("Request refused while the output register was empty.");

   a_empty_match : assert property (@(posedge clock) disable iff (reset)
      clear_take ##1 end_take |=> rsp_matched & ~rsp_pattern_overflow)
      else $error("Empty subject failed to match the empty pattern.");

endmodule

bind glob_wildcard_match gwm_checker u_gwm_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .req_type             (req_type),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_matched          (rsp_matched),
   .rsp_pattern_overflow (rsp_pattern_overflow)
);
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glob wildcard matcher testbench
// A short table of directed transactions is followed by random pattern loads
// and subjects, each built to match its pattern, some of them then mutated.
// Every accepted transaction is tracked by a position-set model of the
// matcher, and each verdict is compared with the oldest expected one. Both
// channels idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;

   localparam int PAT_CAP = 32;
   localparam int RANDOM_ITEMS = 710;
   localparam int HOLD_CYCLES = 80;
   localparam int DRAIN_LIMIT = 2000;
   localparam longint TIMEOUT_NS = 2_000_000;

   typedef struct packed {
      logic matched;
      logic overflow;
   } verdict_type;

   typedef struct {
      gwm_pkg::req_code_type code;
      logic [7:0]            value;
      int unsigned           count;
      logic                  pinned;
      logic                  matched;
      logic                  overflow;
   } drill_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_type;
   logic [7:0] req_byte_value;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_matched;
   logic       rsp_pattern_overflow;

   logic pin_known;
   logic pin_matched;
   logic pin_overflow;
   logic hold_pending;

   int unsigned send_idle_pct;
   int unsigned rsp_idle_pct;
   int unsigned items_sent;
   int unsigned verdicts_checked;
   int unsigned matches_seen;
   int unsigned overflows_seen;
   int unsigned fail_count;

   logic [7:0]       pat_bytes [PAT_CAP];
   int unsigned      pat_len;
   logic             pat_overflow;
   logic [PAT_CAP:0] live_pos;
   verdict_type      pending_verdicts [$];

   drill_row_type drill_rows [27];

   glob_wildcard_match #(.MAX_PATTERN(PAT_CAP)) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_type             (req_type),
      .req_byte_value       (req_byte_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_matched          (rsp_matched),
      .rsp_pattern_overflow (rsp_pattern_overflow)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic logic [PAT_CAP:0] star_closure(input logic [PAT_CAP:0] set);
      logic [PAT_CAP:0] spread;
      spread = set;
      for (int i = 0; i < PAT_CAP; i++) begin
         if (i < pat_len && spread[i] && pat_bytes[i] == gwm_pkg::ANY_RUN) begin
            spread[i + 1] = 1'b1;
         end
      end
      return spread;
   endfunction

   task automatic track_request(input gwm_pkg::req_code_type code, input logic [7:0] value);
      logic [PAT_CAP:0] cur;
      logic [PAT_CAP:0] nxt;
      verdict_type      v;
      case (code)
         gwm_pkg::REQ_CLEAR: begin
            pat_len = 0;
            pat_overflow = 1'b0;
            live_pos = (PAT_CAP + 1)'(1);
         end
         gwm_pkg::REQ_APPEND: begin
            if (pat_len < PAT_CAP) begin
               pat_bytes[pat_len] = value;
               pat_len++;
            end else begin
               pat_overflow = 1'b1;
            end
         end
         gwm_pkg::REQ_SUBJECT: begin
            cur = star_closure(live_pos);
            nxt = '0;
            for (int i = 0; i < PAT_CAP; i++) begin
               if (i < pat_len && cur[i]) begin
                  if (pat_bytes[i] == gwm_pkg::ANY_RUN) begin
                     nxt[i] = 1'b1;
                  end else if (pat_bytes[i] == gwm_pkg::ANY_ONE || pat_bytes[i] == value) begin
                     nxt[i + 1] = 1'b1;
                  end
               end
            end
            live_pos = nxt;
         end
         default: begin
            cur = star_closure(live_pos);
            v.matched = cur[pat_len] && !pat_overflow;
            v.overflow = pat_overflow;
            if (pin_known) begin
               v.matched = pin_matched;
               v.overflow = pin_overflow;
            end
            pending_verdicts.push_back(v);
            live_pos = (PAT_CAP + 1)'(1);
         end
      endcase
   endtask

   always @(posedge clock) begin
      verdict_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            track_request(gwm_pkg::req_code_type'(req_type), req_byte_value);
         end
         if (rsp_valid && rsp_ready) begin
            verdicts_checked++;
            if (rsp_matched === 1'b1) matches_seen++;
            if (rsp_pattern_overflow === 1'b1) overflows_seen++;
            if (pending_verdicts.size() == 0) begin
               $error("verdict transaction with none expected");
               fail_count++;
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_matched !== want.matched) begin
                  $error("rsp_matched: expected %0b, got %0b", want.matched, rsp_matched);
                  fail_count++;
               end
               if (rsp_pattern_overflow !== want.overflow) begin
                  $error("rsp_pattern_overflow: expected %0b, got %0b",
                         want.overflow, rsp_pattern_overflow);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic send_item(input gwm_pkg::req_code_type code, input logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= code;
      req_byte_value <= value;
      items_sent++;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [7:0] pattern_byte();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 25) return gwm_pkg::ANY_RUN;
      if (r < 45) return gwm_pkg::ANY_ONE;
      if (r < 85) return 8'h61 + 8'($urandom_range(1));
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] subject_byte();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 30) return 8'h61;
      if (r < 60) return 8'h62;
      if (r < 80) return gwm_pkg::ANY_RUN;
      return 8'($urandom);
   endfunction

   task automatic send_sequence();
      logic [7:0]  pat [$];
      logic [7:0]  subj [$];
      int unsigned len;
      int unsigned r;
      int unsigned spot;
      r = $urandom_range(99);
      if (r < 5) len = $urandom_range(36, 33);
      else if (r < 15) len = $urandom_range(32, 20);
      else len = $urandom_range(8, 0);
      send_item(gwm_pkg::REQ_CLEAR, 8'($urandom));
      repeat (len) begin
         pat.push_back(pattern_byte());
         send_item(gwm_pkg::REQ_APPEND, pat[$]);
      end
      repeat ($urandom_range(4, 1)) begin
         subj.delete();
         foreach (pat[i]) begin
            if (i < PAT_CAP) begin
               if (pat[i] == gwm_pkg::ANY_RUN) begin
                  repeat ($urandom_range(3, 0)) subj.push_back(subject_byte());
               end else if (pat[i] == gwm_pkg::ANY_ONE) begin
                  subj.push_back(subject_byte());
               end else begin
                  subj.push_back(pat[i]);
               end
            end
         end
         if ($urandom_range(99) < 40) begin
            r = $urandom_range(2);
            if (r == 0) begin
               spot = $urandom_range(subj.size());
               subj.insert(spot, subject_byte());
            end else if (subj.size() != 0) begin
               spot = $urandom_range(subj.size() - 1);
               if (r == 1) subj.delete(spot);
               else subj[spot] = subject_byte();
            end
         end
         foreach (subj[i]) begin
            if ($urandom_range(99) < 3) begin
               send_item(gwm_pkg::req_code_type'($urandom_range(3)), 8'($urandom));
            end
            send_item(gwm_pkg::REQ_SUBJECT, subj[i]);
         end
         send_item(gwm_pkg::REQ_END, 8'($urandom));
      end
   endtask

   initial begin
      #(TIMEOUT_NS);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int unsigned base;
      int unsigned drain;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = gwm_pkg::REQ_CLEAR;
      req_byte_value = 8'h00;
      pin_known = 1'b0;
      pin_matched = 1'b0;
      pin_overflow = 1'b0;
      hold_pending = 1'b0;
      send_idle_pct = 29;
      rsp_idle_pct = 72;
      items_sent = 0;
      verdicts_checked = 0;
      matches_seen = 0;
      overflows_seen = 0;
      fail_count = 0;
      pat_len = 0;
      pat_overflow = 1'b0;
      live_pos = (PAT_CAP + 1)'(1);
      foreach (pat_bytes[i]) pat_bytes[i] = 8'h00;
      drill_rows = '{
         '{gwm_pkg::REQ_END,     8'h00, 1,  1'b1, 1'b1, 1'b0},
         '{gwm_pkg::REQ_SUBJECT, 8'h00, 1,  1'b0, 1'b0, 1'b0},
         '{gwm_pkg::REQ_END,     8'hFF, 1,  1'b1, 1'b0, 1'b0},
         '{gwm_pkg::REQ_APPEND,  8'h2A, 1,  1'b0, 1'b0, 1'b0},
         '{gwm_pkg::REQ_END,     8'h00, 1,  1'b0, 1'b0, 1'b0},
         '{gwm_pkg::REQ_SUBJECT, 8'hFF, 1,  1'b0, 1'b0, 1'b0},
         '{gwm_pkg::REQ_SUBJECT, 8'h2A, 1,  1'b0, 1'b0, 1'b0},
         '{gwm_pkg::REQ_END,     8'h00, 1,  1'b0, 1'b0, 1'b0},
         '{gwm_pkg::REQ_CLEAR,   8'hFF, 1,  1'b0, 1'b0, 1'b0},
         '{gwm_pkg::REQ_APPEND,  8'h00, 1,  1'b0, 1'b0, 1'b0},
         '{gwm_pkg::REQ_APPEND,  8'h3F, 1,  1'b0, 1'b0, 1'b0},
         '{gwm_pkg::REQ_SUBJECT, 8'h00, 1,  1'b0, 1'b0, 1'b0},
         '{gwm_pkg::REQ_APPEND,  8'hFF, 1,  1'b0, 1'b0, 1'b0},
         '{gwm_pkg::REQ_SUBJECT, 8'h41, 1,  1'b0, 1'b0, 1'b0},
         '{gwm_pkg::REQ_SUBJECT, 8'hFF, 1,  1'b0, 1'b0, 1'b0},
         '{gwm_pkg::REQ_END,     8'h00, 1,  1'b0, 1'b0, 1'b0},
         '{gwm_pkg::REQ_SUBJECT, 8'h2A, 1,  1'b0, 1'b0, 1'b0},
         '{gwm_pkg::REQ_END,     8'h00, 1,  1'b0, 1'b0, 1'b0},
         '{gwm_pkg::REQ_CLEAR,   8'h00, 1,  1'b0, 1'b0, 1'b0},
         '{gwm_pkg::REQ_APPEND,  8'h3F, 32, 1'b0, 1'b0, 1'b0},
         '{gwm_pkg::REQ_SUBJECT, 8'h5A, 32, 1'b0, 1'b0, 1'b0},
         '{gwm_pkg::REQ_END,     8'h00, 1,  1'b0, 1'b0, 1'b0},
         '{gwm_pkg::REQ_APPEND,  8'h00, 1,  1'b0, 1'b0, 1'b0},
         '{gwm_pkg::REQ_END,     8'h00, 1,  1'b1, 1'b0, 1'b1},
         '{gwm_pkg::REQ_SUBJECT, 8'h3F, 1,  1'b0, 1'b0, 1'b0},
         '{gwm_pkg::REQ_CLEAR,   8'h00, 1,  1'b0, 1'b0, 1'b0},
         '{gwm_pkg::REQ_END,     8'h00, 1,  1'b1, 1'b1, 1'b0}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (drill_rows[k]) begin
         pin_known <= drill_rows[k].pinned;
         pin_matched <= drill_rows[k].matched;
         pin_overflow <= drill_rows[k].overflow;
         repeat (drill_rows[k].count) send_item(drill_rows[k].code, drill_rows[k].value);
      end
      pin_known <= 1'b0;

      base = items_sent;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 72 : 0;
         rsp_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 29 : 0;
         if (phase == 0) begin
            hold_pending = 1'b1;
            repeat (4) send_sequence();
            req_valid <= 1'b0;
            while (pending_verdicts.size() != 0) @(posedge clock);
         end
         while (items_sent < base + (phase + 1) * RANDOM_ITEMS / 3) send_sequence();
      end
      req_valid <= 1'b0;

      drain = 0;
      while (pending_verdicts.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);
      if (pending_verdicts.size() != 0) begin
         $error("%0d expected verdicts never arrived", pending_verdicts.size());
         fail_count++;
      end

      $display("Sent %0d transactions; checked %0d verdicts, %0d matches, %0d overflowed.",
               items_sent, verdicts_checked, matches_seen, overflows_seen);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
